@@ sv/cmr_pkg.sv @@
package cmr_pkg;

   // sizing
   localparam int NUM_STREAMS = 4;
   localparam int NUM_ENTRIES = 16;
   localparam int SLOT_W      = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
   localparam int IDX_W       = 4;
   localparam int ADDR_W      = SLOT_W + IDX_W;
   localparam int STORE_DEPTH = NUM_STREAMS * (1 << IDX_W);
   localparam int COUNT_W     = 5;
   localparam int TAG_W       = 24;
   localparam int TICK_W      = 32;
   localparam int ENTRY_W     = 40;
   localparam int FIFO_DEPTH  = 2;
   localparam int FIFO_PTR_W  = 1;
   localparam int FIFO_CNT_W  = 2;

   // entry type that opens a new command
   localparam logic [7:0] HEADER_TYPE = 8'h00;

   // request transfer
   typedef struct packed {
      logic [TAG_W-1:0] stream_tag;
      logic [7:0]       entry_type;
      logic [31:0]      entry_payload;
   } req_type;

   // response transfer
   typedef struct packed {
      logic [7:0]         cmd_id;
      logic [7:0]         cmd_dest;
      logic [7:0]         cmd_source;
      logic [COUNT_W-1:0] cmd_count;
      logic               has_entry;
      logic [IDX_W-1:0]   item_index;
      logic [7:0]         item_type;
      logic [31:0]        item_payload;
      logic               last;
   } rsp_type;

   // completed command handed from front to back
   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [7:0]         id;
      logic [7:0]         dest;
      logic [7:0]         source;
      logic [COUNT_W-1:0] count;
   } cmd_type;

   // entry store write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [ENTRY_W-1:0] data;
   } store_wr_type;

   // back has finished reading a slot's entries
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } drain_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_HSCAN,
      F_HCOMMIT,
      F_ELOOK,
      F_EWRITE
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_HEAD,
      B_READ,
      B_DATA
   } back_state_type;

endpackage

@@ sv/cmr_ram.sv @@
module cmr_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/cmr_fifo.sv @@
module cmr_fifo import cmr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_data
);

   cmd_type                 mem_ff [FIFO_DEPTH];
   cmd_type                 mem_in [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         mem_in[wr_ptr_ff] = push_data;
         wr_ptr_in         = wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(1);
      end
      unique case ({push_valid, pop})
         2'b10:   count_in = count_ff + FIFO_CNT_W'(1);
         2'b01:   count_in = count_ff - FIFO_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/cmr_front.sv @@
module cmr_front import cmr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   input  logic         fifo_full,
   output logic         push_valid,
   output cmd_type      push_data,
   output store_wr_type store_wr,
   input  drain_type    drain
);

   front_state_type     state_ff, state_in;
   req_type             item_ff, item_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [SLOT_W-1:0]   sel_ff, sel_in;
   logic [SLOT_W-1:0]   scan_ff, scan_in;
   logic [TICK_W-1:0]   best_age_ff, best_age_in;

   logic [NUM_STREAMS-1:0] busy_ff, busy_in;
   logic [NUM_STREAMS-1:0] pending_ff, pending_in;
   logic [TAG_W-1:0]       tag_ff [NUM_STREAMS];
   logic [TAG_W-1:0]       tag_in [NUM_STREAMS];
   logic [23:0]            hdr_ff [NUM_STREAMS];
   logic [23:0]            hdr_in [NUM_STREAMS];
   logic [COUNT_W-1:0]     count_ff [NUM_STREAMS];
   logic [COUNT_W-1:0]     count_in [NUM_STREAMS];
   logic [COUNT_W-1:0]     fill_ff [NUM_STREAMS];
   logic [COUNT_W-1:0]     fill_in [NUM_STREAMS];
   logic [TICK_W-1:0]      stamp_ff [NUM_STREAMS];
   logic [TICK_W-1:0]      stamp_in [NUM_STREAMS];

   logic                accept;
   logic                any_free;
   logic [SLOT_W-1:0]   first_free;
   logic [7:0]          hdr_cnt;
   logic [COUNT_W-1:0]  cnt_clamp;
   logic [TICK_W-1:0]   age;
   logic                hit;
   logic [SLOT_W-1:0]   match_idx;
   logic [COUNT_W-1:0]  fill_sel;
   logic [COUNT_W-1:0]  fill_next;
   logic [COUNT_W-1:0]  count_sel;
   logic                complete;
   logic                hcommit_ok;
   logic                ewrite_ok;
   logic                hcommit_go;
   logic                ewrite_go;

   assign accept = (state_ff == F_IDLE) && req_valid;

   // first free slot, lowest index wins
   always_comb begin
      any_free   = 1'b0;
      first_free = '0;
      for (int s = NUM_STREAMS - 1; s >= 0; s--) begin
         if (!busy_ff[s]) begin
            any_free   = 1'b1;
            first_free = SLOT_W'(s);
         end
      end
   end

   // first slot whose tag matches, busy or not
   always_comb begin
      hit       = 1'b0;
      match_idx = '0;
      for (int s = NUM_STREAMS - 1; s >= 0; s--) begin
         if (tag_ff[s] == item_ff.stream_tag) begin
            hit       = 1'b1;
            match_idx = SLOT_W'(s);
         end
      end
   end

   // header count clamp and slot age for the scan
   assign hdr_cnt   = item_ff.entry_payload[31:24];
   assign cnt_clamp = (hdr_cnt > 8'(NUM_ENTRIES)) ? COUNT_W'(NUM_ENTRIES)
                                                  : hdr_cnt[COUNT_W-1:0];
   assign age       = tick_ff - stamp_ff[scan_ff];

   // selected slot fill state
   assign fill_sel   = fill_ff[sel_ff];
   assign count_sel  = count_ff[sel_ff];
   assign fill_next  = fill_sel + COUNT_W'(1);
   assign complete   = (fill_next >= count_sel);
   assign hcommit_ok = (cnt_clamp != '0) || !fifo_full;
   assign ewrite_ok  = !pending_ff[sel_ff] && (!complete || !fifo_full);
   assign hcommit_go = (state_ff == F_HCOMMIT) && hcommit_ok;
   assign ewrite_go  = (state_ff == F_EWRITE) && ewrite_ok;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.entry_type == HEADER_TYPE) ? F_HSCAN : F_ELOOK;
            end
         end
         F_HSCAN: begin
            if (any_free || (scan_ff == SLOT_W'(NUM_STREAMS - 1))) begin
               state_in = F_HCOMMIT;
            end
         end
         F_HCOMMIT: begin
            if (hcommit_ok) begin
               state_in = F_IDLE;
            end
         end
         F_ELOOK: begin
            state_in = (hit && busy_ff[match_idx]) ? F_EWRITE : F_IDLE;
         end
         F_EWRITE: begin
            if (ewrite_ok) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // outputs: stall, queue push and store write
   always_comb begin
      req_stall      = (state_ff != F_IDLE);
      push_valid     = 1'b0;
      push_data      = '0;
      store_wr       = '0;
      if (hcommit_go) begin
         push_valid       = (cnt_clamp == '0);
         push_data.slot   = sel_ff;
         push_data.id     = item_ff.entry_payload[7:0];
         push_data.dest   = item_ff.entry_payload[15:8];
         push_data.source = item_ff.entry_payload[23:16];
         push_data.count  = cnt_clamp;
      end else if (ewrite_go) begin
         push_valid       = complete;
         push_data.slot   = sel_ff;
         push_data.id     = hdr_ff[sel_ff][7:0];
         push_data.dest   = hdr_ff[sel_ff][15:8];
         push_data.source = hdr_ff[sel_ff][23:16];
         push_data.count  = count_sel;
         store_wr.en      = (fill_sel < COUNT_W'(NUM_ENTRIES));
         store_wr.addr    = {sel_ff, fill_sel[IDX_W-1:0]};
         store_wr.data    = {item_ff.entry_type, item_ff.entry_payload};
      end
   end

   // slot table and scan registers
   always_comb begin
      item_in     = item_ff;
      tick_in     = tick_ff;
      sel_in      = sel_ff;
      scan_in     = scan_ff;
      best_age_in = best_age_ff;
      busy_in     = busy_ff;
      pending_in  = pending_ff;
      tag_in      = tag_ff;
      hdr_in      = hdr_ff;
      count_in    = count_ff;
      fill_in     = fill_ff;
      stamp_in    = stamp_ff;

      if (accept) begin
         item_in     = req_data;
         tick_in     = tick_ff + TICK_W'(1);
         sel_in      = '0;
         scan_in     = '0;
         best_age_in = '0;
      end

      // oldest slot search, one slot per cycle
      if (state_ff == F_HSCAN) begin
         if (any_free) begin
            sel_in = first_free;
         end else begin
            scan_in = scan_ff + SLOT_W'(1);
            if (age > best_age_ff) begin
               best_age_in = age;
               sel_in      = scan_ff;
            end
         end
      end

      if (state_ff == F_ELOOK) begin
         sel_in = match_idx;
      end

      // open a command in the chosen slot
      if (hcommit_go) begin
         tag_in[sel_ff]   = item_ff.stream_tag;
         hdr_in[sel_ff]   = item_ff.entry_payload[23:0];
         count_in[sel_ff] = cnt_clamp;
         fill_in[sel_ff]  = '0;
         stamp_in[sel_ff] = tick_ff;
         busy_in[sel_ff]  = (cnt_clamp != '0);
      end

      if (drain.valid) begin
         pending_in[drain.slot] = 1'b0;
      end

      // append an entry, hand over on completion
      if (ewrite_go) begin
         fill_in[sel_ff] = fill_next;
         if (complete) begin
            busy_in[sel_ff]    = 1'b0;
            pending_in[sel_ff] = 1'b1;
         end else begin
            stamp_in[sel_ff] = tick_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      sel_ff      <= sel_in;
      scan_ff     <= scan_in;
      best_age_ff <= best_age_in;
      hdr_ff      <= hdr_in;
      count_ff    <= count_in;
      fill_ff     <= fill_in;
      stamp_ff    <= stamp_in;
      if (reset) begin
         state_ff   <= F_IDLE;
         tick_ff    <= '0;
         busy_ff    <= '0;
         pending_ff <= '0;
         for (int s = 0; s < NUM_STREAMS; s++) begin
            tag_ff[s] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         tick_ff    <= tick_in;
         busy_ff    <= busy_in;
         pending_ff <= pending_in;
         tag_ff     <= tag_in;
      end
   end

endmodule

@@ sv/cmr_back.sv @@
module cmr_back import cmr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               fifo_empty,
   output logic               fifo_pop,
   input  cmd_type            fifo_data,
   output logic [ADDR_W-1:0]  rd_addr,
   input  logic [ENTRY_W-1:0] rd_data,
   output drain_type          drain,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data
);

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               out_free;
   logic               last_entry;
   logic               load_head;
   logic               load_entry;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_entry = (({1'b0, idx_ff} + COUNT_W'(1)) == cmd_ff.count);
   assign load_head  = (state_ff == B_HEAD) && out_free;
   assign load_entry = (state_ff == B_DATA) && out_free;
   assign rd_addr    = {cmd_ff.slot, idx_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!fifo_empty) begin
               state_in = B_HEAD;
            end
         end
         B_HEAD: begin
            if (out_free) begin
               state_in = (cmd_ff.count == '0) ? B_IDLE : B_READ;
            end
         end
         B_READ: state_in = B_DATA;
         B_DATA: begin
            if (out_free) begin
               state_in = last_entry ? B_IDLE : B_READ;
            end
         end
      endcase
   end

   // outputs to queue and front
   always_comb begin
      fifo_pop    = (state_ff == B_IDLE) && !fifo_empty;
      drain.valid = load_entry && last_entry;
      drain.slot  = cmd_ff.slot;
   end

   // command, index and response register
   always_comb begin
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (fifo_pop) begin
         cmd_in = fifo_data;
         idx_in = '0;
      end

      if (out_free) begin
         rsp_valid_in = load_head || load_entry;
      end

      if (load_head || load_entry) begin
         rsp_in.cmd_id     = cmd_ff.id;
         rsp_in.cmd_dest   = cmd_ff.dest;
         rsp_in.cmd_source = cmd_ff.source;
         rsp_in.cmd_count  = cmd_ff.count;
      end

      // header transfer carries no entry
      if (load_head) begin
         rsp_in.has_entry    = 1'b0;
         rsp_in.item_index   = '0;
         rsp_in.item_type    = '0;
         rsp_in.item_payload = '0;
         rsp_in.last         = (cmd_ff.count == '0);
      end

      if (load_entry) begin
         rsp_in.has_entry    = 1'b1;
         rsp_in.item_index   = idx_ff;
         rsp_in.item_type    = rd_data[39:32];
         rsp_in.item_payload = rd_data[31:0];
         rsp_in.last         = last_entry;
         idx_in              = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/multi_stream_command_reassembler.sv @@
// Reassembles commands from interleaved bus frames of several streams.
// req_ channel: one frame per transfer (stream tag, entry type, payload).
// A type-0 entry opens a command in a free slot, or in the least recently
// updated slot when all are busy; other entries append to the slot whose
// tag matches. A completed command leaves on the rsp_ channel as a header
// transfer followed by one transfer per entry, with last on the final one.
// Front: a stored entry passes F_ELOOK and F_EWRITE, a dropped entry only
// F_ELOOK, a header F_HSCAN and F_HCOMMIT; with all slots busy the age
// search walks the slots one per cycle. An entry into a slot whose previous
// command is still being read out waits until that readout has finished.
// Back: a completed command passes a 2-deep queue; the header is loaded in
// B_HEAD, then each entry takes B_READ (one entry store read) and B_DATA.
// When rsp_stall is high the response register holds and the back waits;
// the front keeps taking frames until the queue fills.
// Reset (synchronous) frees every slot, clears tags, tick and the queue;
// the entry store needs no clearing.
module multi_stream_command_reassembler import cmr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic               fifo_full;
   logic               fifo_empty;
   logic               fifo_pop;
   logic               push_valid;
   cmd_type            push_data;
   cmd_type            pop_data;
   store_wr_type       store_wr;
   drain_type          drain;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   cmr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .fifo_full  (fifo_full),
      .push_valid (push_valid),
      .push_data  (push_data),
      .store_wr   (store_wr),
      .drain      (drain)
   );

   cmr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (fifo_full),
      .pop        (fifo_pop),
      .empty      (fifo_empty),
      .pop_data   (pop_data)
   );

   cmr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr.en),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cmr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_pop   (fifo_pop),
      .fifo_data  (pop_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .drain      (drain),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
